/* rtl/wsg_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the waveform sample generator.
package wsg_pkg;

  // Fixed design constants
  localparam int SAMPLES  = 256;
  localparam int DAC_MAX  = 4095;
  localparam int REF_MV   = 3300;

  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int HALF     = SAMPLES / 2;
  localparam int QTR      = SAMPLES / 4;
  localparam int QIDX_W   = $clog2(QTR + 1);
  localparam int CODE_W   = 12;
  localparam int MAG_W    = 15;
  localparam int AMP_W    = 11;
  localparam int MV_W     = 16;
  localparam int CENTER   = DAC_MAX / 2;

  // Amplitude scaling: floor(mv * DAC_MAX / DEN) by reciprocal multiplication
  localparam int          LIM_MV     = REF_MV / 2;
  localparam int          DEN        = 2 * LIM_MV;
  localparam int          AMP_MAX    = DAC_MAX / 2;
  localparam int          PROD_W     = 23;
  localparam int          AMP_SHIFT  = 36;
  localparam int          RECIP_W    = 25;
  localparam longint      AMP_RECIP  = ((64'sd1 <<< AMP_SHIFT) + DEN - 1) / DEN;
  localparam int          RESET_MV   = 1000;
  localparam int          RESET_AMP  = (RESET_MV * DAC_MAX) / DEN;

  // Configuration register indexes
  localparam logic [1:0] REG_WAVE_TYPE  = 2'd0;
  localparam logic [1:0] REG_ZERO_BASED = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd2;

  // Waveform codes; the unused code falls back to sine
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  // Active configuration, with the amplitude already scaled to DAC counts
  typedef struct packed {
    logic [1:0]       wave_type;
    logic             zero_based;
    logic [AMP_W-1:0] amp;
  } wsg_cfg_t;

  typedef logic [MAG_W-1:0] qsine_tab_t [0:QTR];

  localparam longint HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine magnitudes in Q0.15, from a Taylor series in Q2.30.
  function automatic qsine_tab_t make_qsine();
    qsine_tab_t     tab;
    longint         x;
    longint         x2;
    longint         term;
    longint         sum;
    for (int j = 0; j <= QTR; j++) begin
      x    = (longint'(j * 4) * HALF_PI_Q30) / SAMPLES;
      x2   = (x * x) >>> 30;
      sum  = x;
      term = x;
      term = ((term * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      tab[j] = sum[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = make_qsine();

endpackage

/* rtl/waveform_sample_generator_top.sv */
// Top level of the waveform sample generator: phase counter, pipeline and stream ports.
//
//   Channel   Direction  Signals                          Contents
//   s_        in         s_tvalid s_tready s_tdata[7:0]   restart request (bit 0)
//   m_        out        m_tvalid m_tready m_tdata[23:0]  dac_code, sample_index
//                        m_tlast                          period_end
//   cfg_      in         cfg_valid cfg_ready cfg_index    register writes
//                        cfg_data
//
// One request is accepted per cycle while s_tready is high; its result reaches the
// output through an index register and then an output register.
// The phase counter advances at each accepted request, wrapping after SAMPLES.
// Reset clears the phase to 0 and loads the default configuration.
// A stalled output holds its data; the index stage accepts while it is empty or
// its request moves on to the output register in the same cycle.
module waveform_sample_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [11:0] dac_code, [19:12] sample_index, [23:20] zero
  output logic        m_tlast,    // period_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  wsg_pkg::wsg_cfg_t                 cfg;
  logic [wsg_pkg::IDX_W-1:0]         phase;
  logic [wsg_pkg::IDX_W-1:0]         cur_idx;
  logic [wsg_pkg::IDX_W-1:0]         s1_idx;
  logic                              s1_valid;
  logic                              advance;
  logic                              accept;
  logic [wsg_pkg::CODE_W-1:0]        code;
  logic [wsg_pkg::CODE_W-1:0]        out_code;
  logic [wsg_pkg::IDX_W-1:0]         out_idx;
  logic                              out_last;

  wsg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsg_shape u_shape (
    .cfg  (cfg),
    .idx  (s1_idx),
    .code (code)
  );

  // Flow control between the index stage and the output register.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign cur_idx  = s_tdata[0] ? '0 : phase;

  // Control state: phase counter and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        if (cur_idx == wsg_pkg::IDX_W'(wsg_pkg::SAMPLES - 1)) begin
          phase <= '0;
        end else begin
          phase <= cur_idx + 1'b1;
        end
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx <= cur_idx;
    end
    if (advance && s1_valid) begin
      out_code <= code;
      out_idx  <= s1_idx;
      out_last <= (s1_idx == wsg_pkg::IDX_W'(wsg_pkg::SAMPLES - 1));
    end
  end

  assign m_tdata = {4'b0000, out_idx, out_code};
  assign m_tlast = out_last;

endmodule

/* rtl/wsg_cfg.sv */
// Configuration registers, with the millivolt amplitude scaled to DAC counts on write.
module wsg_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [wsg_pkg::MV_W-1:0] cfg_data,
  output wsg_pkg::wsg_cfg_t        cfg
);

  logic [wsg_pkg::AMP_W-1:0]                 mv_sat;
  logic [wsg_pkg::PROD_W-1:0]                mv_prod;
  logic [wsg_pkg::PROD_W+wsg_pkg::RECIP_W-1:0] scaled;
  logic [wsg_pkg::PROD_W+wsg_pkg::RECIP_W-wsg_pkg::AMP_SHIFT-1:0] quot;
  logic [wsg_pkg::AMP_W-1:0]                 amp_next;

  assign cfg_ready = 1'b1;

  // Saturate to half reference, multiply by DAC_MAX, divide by the reference span.
  always_comb begin
    if (cfg_data > wsg_pkg::MV_W'(wsg_pkg::LIM_MV)) begin
      mv_sat = wsg_pkg::AMP_W'(wsg_pkg::LIM_MV);
    end else begin
      mv_sat = cfg_data[wsg_pkg::AMP_W-1:0];
    end
    mv_prod = wsg_pkg::PROD_W'(mv_sat) * wsg_pkg::PROD_W'(wsg_pkg::DAC_MAX);
    scaled  = (wsg_pkg::PROD_W+wsg_pkg::RECIP_W)'(mv_prod) *
              (wsg_pkg::PROD_W+wsg_pkg::RECIP_W)'(wsg_pkg::AMP_RECIP);
    quot    = scaled[wsg_pkg::PROD_W+wsg_pkg::RECIP_W-1:wsg_pkg::AMP_SHIFT];
    if (quot > ($bits(quot))'(wsg_pkg::AMP_MAX)) begin
      amp_next = wsg_pkg::AMP_W'(wsg_pkg::AMP_MAX);
    end else begin
      amp_next = quot[wsg_pkg::AMP_W-1:0];
    end
  end

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_type  <= wsg_pkg::WAVE_SINE;
      cfg.zero_based <= 1'b1;
      cfg.amp        <= wsg_pkg::AMP_W'(wsg_pkg::RESET_AMP);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsg_pkg::REG_WAVE_TYPE:  cfg.wave_type  <= cfg_data[1:0];
        wsg_pkg::REG_ZERO_BASED: cfg.zero_based <= cfg_data[0];
        wsg_pkg::REG_AMPLITUDE:  cfg.amp        <= amp_next;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/wsg_shape.sv */
// Sample code for one phase index: sine, square or triangle, zero based or centred.
module wsg_shape (
  input  wsg_pkg::wsg_cfg_t           cfg,
  input  logic [wsg_pkg::IDX_W-1:0]   idx,
  output logic [wsg_pkg::CODE_W-1:0]  code
);

  localparam int QB_W = wsg_pkg::IDX_W - 2;
  localparam int HB_W = wsg_pkg::IDX_W - 1;

  logic [1:0]                          quadrant;
  logic [QB_W-1:0]                     qoff;
  logic [wsg_pkg::QIDX_W-1:0]          taddr;
  logic [wsg_pkg::MAG_W-1:0]           mag;
  logic                                neg;
  logic [wsg_pkg::MAG_W+wsg_pkg::AMP_W-1:0] prod;
  logic [wsg_pkg::MAG_W+wsg_pkg::AMP_W:0]   zb_sum;
  logic [wsg_pkg::MAG_W+wsg_pkg::AMP_W+2:0] ct_sum;
  logic [wsg_pkg::CODE_W-1:0]          sine_code;
  logic [wsg_pkg::CODE_W-1:0]          high;
  logic [wsg_pkg::CODE_W-1:0]          low;
  logic [wsg_pkg::CODE_W-1:0]          span;
  logic [HB_W+wsg_pkg::CODE_W-1:0]     ramp_prod;
  logic [wsg_pkg::CODE_W-1:0]          ramp;
  logic [wsg_pkg::CODE_W-1:0]          tri_code;
  logic [wsg_pkg::CODE_W-1:0]          sq_code;

  // Quadrant folding into the quarter-wave table.
  always_comb begin
    quadrant = idx[wsg_pkg::IDX_W-1 -: 2];
    qoff     = idx[QB_W-1:0];
    if (quadrant[0]) begin
      taddr = wsg_pkg::QIDX_W'(wsg_pkg::QTR) - wsg_pkg::QIDX_W'(qoff);
    end else begin
      taddr = wsg_pkg::QIDX_W'(qoff);
    end
    mag = wsg_pkg::QSINE[taddr];
    neg = quadrant[1];
  end

  // Sine scaling: one magnitude product serves both output forms.
  always_comb begin
    prod = ($bits(prod))'(mag) * ($bits(prod))'(cfg.amp);
    if (neg) begin
      zb_sum = (($bits(zb_sum))'(cfg.amp) << 15) - ($bits(zb_sum))'(prod);
      ct_sum = (($bits(ct_sum))'(wsg_pkg::DAC_MAX) << 15) - (($bits(ct_sum))'(prod) << 1);
    end else begin
      zb_sum = (($bits(zb_sum))'(cfg.amp) << 15) + ($bits(zb_sum))'(prod);
      ct_sum = (($bits(ct_sum))'(wsg_pkg::DAC_MAX) << 15) + (($bits(ct_sum))'(prod) << 1);
    end
    if (cfg.zero_based) begin
      sine_code = zb_sum[15 +: wsg_pkg::CODE_W];
    end else begin
      sine_code = ct_sum[16 +: wsg_pkg::CODE_W];
    end
  end

  // Levels shared by square and triangle.
  always_comb begin
    if (cfg.zero_based) begin
      high = wsg_pkg::CODE_W'(cfg.amp) << 1;
      low  = '0;
    end else begin
      high = wsg_pkg::CODE_W'(wsg_pkg::CENTER) + wsg_pkg::CODE_W'(cfg.amp);
      low  = wsg_pkg::CODE_W'(wsg_pkg::CENTER) - wsg_pkg::CODE_W'(cfg.amp);
    end
    span = high - low;
  end

  // Square: high for the first half period.
  assign sq_code = idx[wsg_pkg::IDX_W-1] ? low : high;

  // Triangle: linear ramp over each half with fixed endpoints.
  always_comb begin
    ramp_prod = ($bits(ramp_prod))'(idx[HB_W-1:0]) * ($bits(ramp_prod))'(span);
    ramp      = ramp_prod[HB_W +: wsg_pkg::CODE_W];
    if (idx == '0 || idx == wsg_pkg::IDX_W'(wsg_pkg::SAMPLES - 1)) begin
      tri_code = low;
    end else if (idx == wsg_pkg::IDX_W'(wsg_pkg::HALF - 1)) begin
      tri_code = high;
    end else if (!idx[wsg_pkg::IDX_W-1]) begin
      tri_code = low + ramp;
    end else begin
      tri_code = high - ramp;
    end
  end

  // Waveform select; the unused code produces sine.
  always_comb begin
    case (cfg.wave_type)
      wsg_pkg::WAVE_SQUARE:   code = sq_code;
      wsg_pkg::WAVE_TRIANGLE: code = tri_code;
      default:                code = sine_code;
    endcase
  end

endmodule
